// ===== sv/shs_pkg.sv =====
package shs_pkg;

    localparam int MarkerLen  = 6;
    localparam int QueueDepth = 2;

    localparam logic [7:0] ByteNul    = 8'h00;
    localparam logic [7:0] MarkerHead = 8'h48;

    localparam logic       KindData = 1'b0;
    localparam logic       KindEos  = 1'b1;

    // one flush request handed from the front to the back
    typedef struct packed {
        logic [2:0] held;   // marker bytes to replay, 0..5
        logic       emit;   // pass the data byte after them
        logic [7:0] data;
    } cmd_t;

    function automatic logic [7:0] marker_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h48;
            3'd1:    b = 8'h46;
            3'd2:    b = 8'h53;
            3'd3:    b = 8'h54;
            3'd4:    b = 8'h33;
            default: b = ByteNul;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/shs_front.sv =====
module shs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            kind,
    input  logic [7:0]      in_byte,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            q_full,
    output logic            q_push,
    output shs_pkg::cmd_t   q_cmd
);
    import shs_pkg::*;

    logic [2:0] match_count_reg, match_count_next;
    logic       skipping_reg, skipping_next;
    logic [2:0] mc;
    logic       accept;
    cmd_t       cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign mc       = (match_count_reg >= 3'(MarkerLen)) ? 3'd0 : match_count_reg;

    always_comb
    begin
        match_count_next = match_count_reg;
        skipping_next    = skipping_reg;
        cmd.held         = 3'd0;
        cmd.emit         = 1'b0;
        cmd.data         = in_byte;
        if (accept)
        begin
            match_count_next = mc;
            if (kind == KindEos)
            begin
                cmd.held         = mc;
                match_count_next = 3'd0;
                skipping_next    = 1'b0;
            end
            else if (skipping_reg)
            begin
                if (in_byte == ByteNul)
                    skipping_next = 1'b0;
            end
            else if (in_byte == marker_byte(mc))
            begin
                if (mc == 3'(MarkerLen - 1))
                begin
                    skipping_next    = 1'b1;
                    match_count_next = 3'd0;
                end
                else
                    match_count_next = mc + 3'd1;
            end
            else
            begin
                // broken match: replay held bytes, then re-examine this byte
                cmd.held = mc;
                if (in_byte == MarkerHead)
                    match_count_next = 3'd1;
                else
                begin
                    match_count_next = 3'd0;
                    cmd.emit         = 1'b1;
                end
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && ((cmd.held != 3'd0) || cmd.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= 3'd0;
            skipping_reg    <= 1'b0;
        end
        else
        begin
            match_count_reg <= match_count_next;
            skipping_reg    <= skipping_next;
        end
    end

endmodule

// ===== sv/shs_queue.sv =====
module shs_queue #(
    parameter int Depth = shs_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  shs_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output shs_pkg::cmd_t   pop_cmd,
    output logic            empty
);
    import shs_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            slots_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slots_reg[rd_ptr_reg];

    function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CntW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CntW'(1);
        end
    end

endmodule

// ===== sv/shs_back.sv =====
module shs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  shs_pkg::cmd_t   q_cmd,
    output logic            q_pop,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_valid,
    input  logic            out_ready
);
    import shs_pkg::*;

    cmd_t       cmd_reg;
    logic [2:0] idx_reg;
    logic       busy_reg;
    logic       last;
    logic       done;

    assign last = cmd_reg.emit ? (idx_reg == cmd_reg.held)
                               : (idx_reg == cmd_reg.held - 3'd1);
    assign done = busy_reg && out_ready && last;
    assign q_pop = !q_empty && (!busy_reg || done);

    assign out_valid = busy_reg;
    assign out_last  = last;
    assign out_byte  = (idx_reg < cmd_reg.held) ? marker_byte(idx_reg) : cmd_reg.data;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg && out_ready)
            idx_reg <= idx_reg + 3'd1;
    end

endmodule

// ===== sv/stream_header_stripper.sv =====
// channel   signals                                   direction
// input     in_valid in_ready kind in_byte            in
// output    out_valid out_ready out_byte out_last     out
//
// one input byte per cycle while the flush queue has room
// an item yielding k results holds the output side until all k are taken (k up to 6)
// front tracks the marker match, back replays held bytes from a two-deep queue
// asynchronous active-low reset clears match state, queue and output
// a stalled output fills the queue, then in_ready drops
module stream_header_stripper #(
    parameter int QueueDepth = shs_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        kind,
    input  logic [7:0]  in_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_valid,
    input  logic        out_ready
);
    import shs_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    cmd_t push_cmd, pop_cmd;

    shs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .kind     (kind),
        .in_byte  (in_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    shs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    shs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

// ===== sv/shs_checker.sv =====
module shs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  out_byte,
    input  logic        out_last,
    input  logic        out_valid,
    input  logic        out_ready
);
    import shs_pkg::*;

    logic out_fire;
    assign out_fire = out_valid && out_ready;

    // output stays quiet while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled result changed");

    // results of one request come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_last |=> out_valid)
        else $error("gap inside a request's results");

    // only replayed marker bytes can be followed by more results
    a_not_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |->
            out_byte == 8'h48 || out_byte == 8'h46 || out_byte == 8'h53 ||
            out_byte == 8'h54 || out_byte == 8'h33)
        else $error("non-final result is not a marker byte");

    // a replayed head byte is never followed by another head byte
    a_head_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_last && out_byte == MarkerHead |=> out_byte != MarkerHead)
        else $error("head byte repeated within one request");

endmodule

bind stream_header_stripper shs_checker u_shs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

// ===== bench/stream_header_stripper_test.sv =====
module stream_header_stripper_test;

    import shs_pkg::*;

    // marker bytes, first byte in the top lane
    localparam logic [47:0] HDR_MARK = 48'h48_46_53_54_33_00;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } strip_res_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       kind;
    logic [7:0] in_byte;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_valid;
    logic       out_ready;

    strip_res_t strip_q [$];
    strip_res_t got_exp;
    logic [2:0] hdr_match;
    logic       hdr_skip;

    int  mismatches = 0;
    int  items_sent = 0;
    bit  idle_on = 1'b1;
    bit  rx_holding = 1'b0;
    int  rx_burst = 0;
    event hold_trig;

    stream_header_stripper DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (kind),
        .in_byte   (in_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] hdr_byte(input int idx);
        return HDR_MARK[47 - 8 * idx -: 8];
    endfunction

    // expected output bytes for one accepted request
    function automatic void predict_strip(input logic k, input logic [7:0] b);
        logic [7:0] res [6];
        int  cnt;
        int  held;
        bit  do_flush;
        bit  restart;
        bit  pass_byte;
        cnt = 0;
        do_flush = 1'b0;
        restart = 1'b0;
        pass_byte = 1'b0;
        if (hdr_match > 3'd5)
            hdr_match = 3'd0;
        held = int'(hdr_match);
        if (k == KindEos)
        begin
            do_flush = 1'b1;
            hdr_skip = 1'b0;
        end
        else if (hdr_skip)
        begin
            if (b == ByteNul)
                hdr_skip = 1'b0;
        end
        else if (b == hdr_byte(held))
        begin
            if (held == MarkerLen - 1)
            begin
                hdr_skip = 1'b1;
                hdr_match = 3'd0;
            end
            else
                hdr_match = hdr_match + 3'd1;
        end
        else
        begin
            do_flush = 1'b1;
            // the breaking byte is looked at again from the start
            if (b == hdr_byte(0))
                restart = 1'b1;
            else
                pass_byte = 1'b1;
        end
        if (do_flush)
        begin
            for (int i = 0; i < held; i++)
            begin
                res[cnt] = hdr_byte(i);
                cnt++;
            end
            hdr_match = restart ? 3'd1 : 3'd0;
        end
        if (pass_byte)
        begin
            res[cnt] = b;
            cnt++;
        end
        for (int i = 0; i < cnt; i++)
            strip_q.push_back('{data: res[i], last: (i == cnt - 1)});
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_item(input logic k, input logic [7:0] b);
        int gap;
        kind = k;
        in_byte = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_strip(k, b);
        items_sent++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_marker(input int len);
        for (int i = 0; i < len; i++)
            send_item(KindData, hdr_byte(i));
    endtask

    task automatic wait_drain();
        in_valid = 1'b0;
        while (strip_q.size() != 0)
            @(negedge clk);
    endtask

    // half the time a marker byte, so matches start often
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 1)
            b = hdr_byte($urandom_range(0, 5));
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_segment();
        int sel;
        int len;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
        begin
            send_marker(MarkerLen);
            len = $urandom_range(0, 4);
            repeat (len) send_item(KindData, pick_byte());
            if ($urandom_range(0, 4) != 0)
                send_item(KindData, ByteNul);
            else
                send_item(KindEos, 8'($urandom_range(0, 255)));
        end
        else if (sel <= 5)
        begin
            send_marker($urandom_range(1, 5));
            if ($urandom_range(0, 3) != 0)
                send_item(KindData, pick_byte());
            else
                send_item(KindEos, 8'($urandom_range(0, 255)));
        end
        else if (sel <= 8)
        begin
            len = $urandom_range(1, 4);
            repeat (len) send_item(KindData, pick_byte());
        end
        else
            send_item(KindEos, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_plain_bytes();
        send_item(KindData, 8'h00);
        send_item(KindData, 8'hff);
        send_item(KindData, 8'h5a);
        wait_drain();
    endtask

    task automatic test_header_removal();
        send_marker(MarkerLen);
        send_item(KindData, 8'h61);
        send_item(KindData, ByteNul);
        send_item(KindData, 8'h62);
        wait_drain();
    endtask

    task automatic test_marker_mismatch();
        // longest partial match, six bytes out at once
        send_marker(MarkerLen - 1);
        send_item(KindData, 8'h7a);
        wait_drain();
    endtask

    task automatic test_repeated_head();
        send_item(KindData, MarkerHead);
        send_item(KindData, MarkerHead);
        send_item(KindData, 8'h78);
        wait_drain();
    endtask

    task automatic test_end_of_stream();
        send_marker(2);
        send_item(KindEos, 8'hff);
        send_item(KindEos, 8'h00);
        wait_drain();
    endtask

    task automatic test_random_stream(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_segment();
        wait_drain();
    endtask

    task automatic test_output_stall();
        -> hold_trig;
        repeat (8)
        begin
            send_marker($urandom_range(3, 5));
            send_item(KindData, 8'h21);
        end
        // sender pauses until the block has emptied
        wait_drain();
    endtask

    task automatic test_no_idle(input int count);
        idle_on = 1'b0;
        test_random_stream(count);
    endtask

    // long receiver hold-off, counted on rising edges
    always
    begin
        @(hold_trig);
        @(posedge clk);
        rx_holding = 1'b1;
        repeat (60) @(posedge clk);
        rx_holding = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rx_holding)
            out_ready = 1'b0;
        else if (rx_burst > 0)
        begin
            out_ready = 1'b0;
            rx_burst--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready = 1'b0;
            rx_burst = $urandom_range(1, 6) - 1;
        end
        else
            out_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (strip_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected output byte %h last %b", out_byte, out_last);
                mismatches++;
            end
            else
            begin
                got_exp = strip_q.pop_front();
                if (out_byte !== got_exp.data || out_last !== got_exp.last)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                 got_exp.data, got_exp.last, out_byte, out_last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        kind = KindData;
        in_byte = 8'h00;
        in_valid = 1'b0;
        hdr_match = 3'd0;
        hdr_skip = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_plain_bytes();
        test_header_removal();
        test_marker_mismatch();
        test_repeated_head();
        test_end_of_stream();
        test_random_stream(200);
        test_output_stall();
        test_random_stream(20);
        test_no_idle(40);

        wait_drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && strip_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
